>>> hw/rtl/udiv64_pkg.sv
`timescale 1ns / 1ps

package udiv64_pkg;

	// Width of every operand, quotient and remainder field on the ports
	localparam int unsigned WORD_W = 64;

	// One division request
	typedef struct packed {
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	// One division result
	typedef struct packed {
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
		logic              divide_by_zero;
	} div_res_t;

endpackage

>>> hw/rtl/unsigned_divide_64.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  div_req_t  (dividend, divisor)
// res       out        res_valid/res_stall  div_res_t  (quotient, remainder, divide_by_zero)
//
// Each pipeline stage does one restoring step (a DATA_WIDTH+2 bit subtract), and the
// output register follows. One request is taken every cycle while req_stall is low.
// A zero divisor runs through the same stages and returns all ones with the
// dividend as remainder, flagged. Reset clears only the valid bits.
// A stalled result moves into a one-entry skid register; the pipeline, and with it
// req_stall, holds only while that skid register is occupied.
module unsigned_divide_64 #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  udiv64_pkg::div_req_t  req,
	output logic                  res_valid,
	input  logic                  res_stall,
	output udiv64_pkg::div_res_t  res
);
	import udiv64_pkg::*;

	localparam int unsigned DW = DATA_WIDTH;

	// Stage j holds the state after j+1 restoring steps
	logic [DW-1:0] rem_s [DW];
	logic [DW-1:0] nq_s  [DW];   // remaining dividend bits above, quotient bits below
	logic [DW-1:0] den_s [DW];
	logic [DW-1:0] dbz_s;
	logic [DW-1:0] vld_s;

	logic [DW-1:0] nxt_rem [DW];
	logic [DW-1:0] nxt_nq  [DW];

	div_res_t res_q;
	div_res_t skid_q;
	div_res_t last_res;
	logic     res_vld_q;
	logic     skid_vld_q;
	logic     adv;
	logic     last_go;
	logic     take;

	// Advance the whole pipeline unless the skid register holds a request
	assign adv       = !skid_vld_q;
	assign req_stall = skid_vld_q;
	assign last_go   = vld_s[DW-1] && adv;
	assign take      = res_vld_q && !res_stall;

	// One restoring step per stage: shift in a dividend bit, subtract if it fits
	for (genvar j = 0; j < DW; j++) begin : g_step
		logic [DW-1:0] src_rem;
		logic [DW-1:0] src_nq;
		logic [DW-1:0] src_den;
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		logic          fits;

		if (j == 0) begin : g_first
			assign src_rem = '0;
			assign src_nq  = req.dividend[DW-1:0];
			assign src_den = req.divisor[DW-1:0];
		end else begin : g_next
			assign src_rem = rem_s[j-1];
			assign src_nq  = nq_s[j-1];
			assign src_den = den_s[j-1];
		end

		assign trial      = {src_rem, src_nq[DW-1]};
		assign diff       = {1'b0, trial} - {2'b00, src_den};
		assign fits       = !diff[DW+1];
		assign nxt_rem[j] = fits ? diff[DW-1:0] : trial[DW-1:0];
		assign nxt_nq[j]  = {src_nq[DW-2:0], fits};
	end

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[DW-2:0], req_valid};
		end
	end

	// Advance the stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			dbz_s <= {dbz_s[DW-2:0], (req.divisor[DW-1:0] == '0)};
			for (int j = 0; j < DW; j++) begin
				rem_s[j] <= nxt_rem[j];
				nq_s[j]  <= nxt_nq[j];
			end
			den_s[0] <= req.divisor[DW-1:0];
			for (int j = 1; j < DW; j++) begin
				den_s[j] <= den_s[j-1];
			end
		end
	end

	// Widen the finished request to the port fields
	always_comb begin
		last_res.quotient       = WORD_W'(nq_s[DW-1]);
		last_res.remainder      = WORD_W'(rem_s[DW-1]);
		last_res.divide_by_zero = dbz_s[DW-1];
	end

	// Output register and skid register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (last_go) begin
			if (!res_vld_q || take) begin
				res_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end else if (take) begin
			res_vld_q  <= skid_vld_q;
			skid_vld_q <= 1'b0;
		end
	end

	// Load the output from the pipeline, or drain the skid register into it
	always_ff @(posedge clk) begin
		if (last_go && (!res_vld_q || take)) begin
			res_q <= last_res;
		end else if (take && skid_vld_q) begin
			res_q <= skid_q;
		end
		if (last_go && res_vld_q && !take) begin
			skid_q <= last_res;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

	// The skid register only fills behind a waiting output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> res_vld_q)
		else $error("skid register occupied with empty output");

	// A full skid register freezes every stage
	a_hold_on_skid: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(vld_s))
		else $error("pipeline moved while skid register full");

	// A finished request arriving at a stalled output must land in the skid register
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(last_go && res_vld_q && res_stall) |=> skid_vld_q)
		else $error("finished request lost at stalled output");

	// A zero divisor yields an all-ones quotient
	a_zero_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.divide_by_zero) |-> (res_q.quotient[DW-1:0] == '1))
		else $error("zero divisor without all-ones quotient");

endmodule
